// ===== rtl/lav_pkg.sv =====
// ============================================================================
// Look-at view matrix package
// Shared widths and fixed-point constants for the look-at view matrix core.
// ============================================================================
package lav_pkg;

    localparam int COORD_W   = 32;
    localparam int AXIS_W    = 18;
    localparam int AXIS_FRAC = 16;
    localparam int NORM_TOP  = 29;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int CROSS_W   = COORD_W + AXIS_W + 1;

endpackage

// ===== rtl/lav_norm.sv =====
// ============================================================================
// Vector normalization pipeline
// Block-scales a signed integer 3-vector, takes a bit-per-stage square root
// of its squared length and divides each component by it, one quotient bit
// per stage. A sideband word travels with every transaction.
// ============================================================================
module lav_norm #(
    parameter int VW  = 33,
    parameter int SBW = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_ok,
    input  logic signed [VW-1:0]                i_v [3],
    input  logic [SBW-1:0]                      i_sb,
    output logic                                o_valid,
    output logic                                o_ok,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_q [3],
    output logic [SBW-1:0]                      o_sb
);
    import lav_pkg::*;

    localparam int PW  = $clog2(VW);
    localparam int NW  = NORM_TOP + 1;
    localparam int SW  = 2 * NW + 2;
    localparam int RW  = SW / 2;
    localparam int RMW = RW + 2;
    localparam int QW  = AXIS_FRAC + 1;
    localparam int NNW = NW + AXIS_FRAC + 1;
    localparam int DRW = RW + 1;

    typedef struct packed {
        logic                   ok;
        logic [2:0]             neg;
        logic [2:0][NW-1:0]     m;
        logic [SBW-1:0]         sb;
    } t_carry;

    typedef struct packed {
        logic                   ok;
        logic [2:0]             neg;
        logic [SBW-1:0]         sb;
    } t_dcarry;

    // Magnitude stage.
    logic               r1_valid;
    logic               r1_ok;
    logic [VW-1:0]      r1_m [3];
    logic [2:0]         r1_neg;
    logic [SBW-1:0]     r1_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok <= i_ok;
            r1_sb <= i_sb;
            for (int j = 0; j < 3; j++) begin
                r1_neg[j] <= i_v[j][VW-1];
                r1_m[j]   <= i_v[j][VW-1] ? $unsigned(-i_v[j]) : $unsigned(i_v[j]);
            end
        end
    end

    // Leading-one stage.
    logic [VW-1:0]      orv;
    logic [PW-1:0]      n_p;
    logic               r2_valid;
    logic               r2_ok;
    logic               r2_nz;
    logic [PW-1:0]      r2_p;
    logic [VW-1:0]      r2_m [3];
    logic [2:0]         r2_neg;
    logic [SBW-1:0]     r2_sb;

    always_comb begin
        orv = r1_m[0] | r1_m[1] | r1_m[2];
        n_p = '0;
        for (int b = 0; b < VW; b++) begin
            if (orv[b]) begin
                n_p = PW'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ok  <= r1_ok;
            r2_nz  <= |orv;
            r2_p   <= n_p;
            r2_m   <= r1_m;
            r2_neg <= r1_neg;
            r2_sb  <= r1_sb;
        end
    end

    // Block-scaling stage.
    logic [63:0]        wide [3];
    logic [NW-1:0]      n_sh [3];
    logic               r3_valid;
    t_carry             r3_c;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            wide[j] = 64'(r2_m[j]);
            if (r2_p > PW'(NORM_TOP)) begin
                n_sh[j] = NW'(wide[j] >> (r2_p - PW'(NORM_TOP)));
            end else begin
                n_sh[j] = NW'(wide[j] << (PW'(NORM_TOP) - r2_p));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_c.ok  <= r2_ok & r2_nz;
            r3_c.neg <= r2_neg;
            r3_c.sb  <= r2_sb;
            for (int j = 0; j < 3; j++) begin
                r3_c.m[j] <= n_sh[j];
            end
        end
    end

    // Squaring stage.
    logic               r4_valid;
    t_carry             r4_c;
    logic [2*NW-1:0]    r4_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_c <= r3_c;
            for (int j = 0; j < 3; j++) begin
                r4_sq[j] <= r3_c.m[j] * r3_c.m[j];
            end
        end
    end

    // Square root, one result bit per stage. Element zero holds the sum.
    logic               r_sq_v    [RW+1];
    t_carry             r_sq_c    [RW+1];
    logic [SW-1:0]      r_sq_s    [RW+1];
    logic [RMW-1:0]     r_sq_rem  [RW+1];
    logic [RW-1:0]      r_sq_root [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (i_en) begin
            r_sq_v[0] <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_c[0]    <= r4_c;
            r_sq_s[0]    <= SW'(r4_sq[0]) + SW'(r4_sq[1]) + SW'(r4_sq[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    for (genvar k = 1; k <= RW; k++) begin : g_sqrt
        localparam int BI = RW - k;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;

        always_comb begin
            rem_sh = {r_sq_rem[k-1][RMW-3:0], r_sq_s[k-1][2*BI+1 -: 2]};
            trial  = {r_sq_root[k-1], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (i_en) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq_c[k]    <= r_sq_c[k-1];
                r_sq_s[k]    <= r_sq_s[k-1];
                r_sq_rem[k]  <= ge ? rem_sh - trial : rem_sh;
                r_sq_root[k] <= {r_sq_root[k-1][RW-2:0], ge};
            end
        end
    end

    // Division, one quotient bit per stage. Element zero holds the dividends.
    logic [NNW-1:0]     n_num [3];
    logic               r_dv_v   [QW+1];
    t_dcarry            r_dv_c   [QW+1];
    logic [RW-1:0]      r_dv_l   [QW+1];
    logic [NNW-1:0]     r_dv_n   [QW+1][3];
    logic [DRW-1:0]     r_dv_rem [QW+1][3];
    logic [QW-1:0]      r_dv_q   [QW+1][3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_num[j] = NNW'({r_sq_c[RW].m[j], AXIS_FRAC'(0)})
                     + NNW'(r_sq_root[RW] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_v[0] <= r_sq_v[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_c[0].ok  <= r_sq_c[RW].ok;
            r_dv_c[0].neg <= r_sq_c[RW].neg;
            r_dv_c[0].sb  <= r_sq_c[RW].sb;
            r_dv_l[0]     <= r_sq_root[RW];
            for (int j = 0; j < 3; j++) begin
                r_dv_n[0][j]   <= n_num[j];
                r_dv_rem[0][j] <= DRW'(n_num[j] >> QW);
                r_dv_q[0][j]   <= '0;
            end
        end
    end

    for (genvar d = 1; d <= QW; d++) begin : g_div
        logic [DRW-1:0] dsh [3];
        logic [2:0]     dge;

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                dsh[j] = {r_dv_rem[d-1][j][DRW-2:0], r_dv_n[d-1][j][QW-d]};
                dge[j] = (dsh[j] >= {1'b0, r_dv_l[d-1]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[d] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[d] <= r_dv_v[d-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_c[d] <= r_dv_c[d-1];
                r_dv_l[d] <= r_dv_l[d-1];
                for (int j = 0; j < 3; j++) begin
                    r_dv_n[d][j]   <= r_dv_n[d-1][j];
                    r_dv_rem[d][j] <= dge[j] ? dsh[j] - {1'b0, r_dv_l[d-1]} : dsh[j];
                    r_dv_q[d][j]   <= {r_dv_q[d-1][j][QW-2:0], dge[j]};
                end
            end
        end
    end

    // Sign stage.
    logic [AXIS_W-1:0]  qmag [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            qmag[j] = AXIS_W'(r_dv_q[QW][j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_dv_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ok <= r_dv_c[QW].ok;
            o_sb <= r_dv_c[QW].sb;
            for (int j = 0; j < 3; j++) begin
                o_q[j] <= r_dv_c[QW].neg[j] ? -qmag[j] : qmag[j];
            end
        end
    end

endmodule

// ===== rtl/lav_back.sv =====
// ============================================================================
// Look-at back end
// Forms the recomputed up axis from forward and side, the three translation
// terms, and zeroes the whole result for degenerate inputs.
// ============================================================================
module lav_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_ok,
    input  logic signed [lav_pkg::AXIS_W-1:0]   i_fwd [3],
    input  logic signed [lav_pkg::AXIS_W-1:0]   i_side [3],
    input  logic signed [lav_pkg::COORD_W-1:0]  i_eye [3],
    output logic                                o_valid,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_side [3],
    output logic signed [lav_pkg::AXIS_W-1:0]   o_upn [3],
    output logic signed [lav_pkg::AXIS_W-1:0]   o_fwd [3],
    output logic signed [lav_pkg::COORD_W-1:0]  o_trans [3]
);
    import lav_pkg::*;

    localparam int PAW = 2 * AXIS_W;
    localparam int UDW = PAW + 1;
    localparam int EPW = COORD_W + AXIS_W;
    localparam int DTW = EPW + 2;
    localparam int TRW = DTW - AXIS_FRAC;

    function automatic logic signed [AXIS_W-1:0] round_axis(input logic signed [UDW-1:0] x);
        logic [UDW-1:0]             m;
        logic [UDW-AXIS_FRAC-1:0]   r;
        logic [AXIS_W-1:0]          v;
        m = x[UDW-1] ? $unsigned(-x) : $unsigned(x);
        r = (UDW-AXIS_FRAC)'((m + UDW'(1 << (AXIS_FRAC - 1))) >> AXIS_FRAC);
        if (r > (UDW-AXIS_FRAC)'(1 << AXIS_FRAC)) begin
            r = (UDW-AXIS_FRAC)'(1 << AXIS_FRAC);
        end
        v = AXIS_W'(r);
        return x[UDW-1] ? -v : v;
    endfunction

    function automatic logic signed [COORD_W-1:0] trans_sat(input logic signed [DTW-1:0] x);
        logic [DTW-1:0]     m;
        logic [TRW-1:0]     r;
        logic [COORD_W-1:0] t;
        m = x[DTW-1] ? $unsigned(-x) : $unsigned(x);
        r = TRW'((m + DTW'(1 << (AXIS_FRAC - 1))) >> AXIS_FRAC);
        if (x[DTW-1]) begin
            t = (r > TRW'({1'b0, {(COORD_W-1){1'b1}}})) ? {1'b0, {(COORD_W-1){1'b1}}}
                                                         : r[COORD_W-1:0];
        end else begin
            t = (r > TRW'({1'b1, {(COORD_W-1){1'b0}}})) ? {1'b1, {(COORD_W-1){1'b0}}}
                                                         : -r[COORD_W-1:0];
        end
        return t;
    endfunction

    // Products of forward with side, and of the eye with side and forward.
    logic                           r1_valid;
    logic                           r1_ok;
    logic signed [PAW-1:0]          r1_ul [3];
    logic signed [PAW-1:0]          r1_ur [3];
    logic signed [EPW-1:0]          r1_es [3];
    logic signed [EPW-1:0]          r1_ef [3];
    logic signed [AXIS_W-1:0]       r1_side [3];
    logic signed [AXIS_W-1:0]       r1_fwd [3];
    logic signed [COORD_W-1:0]      r1_eye [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ok    <= i_ok;
            r1_side  <= i_side;
            r1_fwd   <= i_fwd;
            r1_eye   <= i_eye;
            r1_ul[0] <= i_fwd[1] * i_side[2];
            r1_ur[0] <= i_fwd[2] * i_side[1];
            r1_ul[1] <= i_fwd[2] * i_side[0];
            r1_ur[1] <= i_fwd[0] * i_side[2];
            r1_ul[2] <= i_fwd[0] * i_side[1];
            r1_ur[2] <= i_fwd[1] * i_side[0];
            for (int j = 0; j < 3; j++) begin
                r1_es[j] <= i_eye[j] * i_side[j];
                r1_ef[j] <= i_eye[j] * i_fwd[j];
            end
        end
    end

    // Up axis rounding and the side and forward dot products.
    logic signed [UDW-1:0]          ud [3];
    logic                           r2_valid;
    logic                           r2_ok;
    logic signed [AXIS_W-1:0]       r2_upn [3];
    logic signed [DTW-1:0]          r2_ds;
    logic signed [DTW-1:0]          r2_df;
    logic signed [AXIS_W-1:0]       r2_side [3];
    logic signed [AXIS_W-1:0]       r2_fwd [3];
    logic signed [COORD_W-1:0]      r2_eye [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ud[j] = UDW'(r1_ul[j]) - UDW'(r1_ur[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ok   <= r1_ok;
            r2_side <= r1_side;
            r2_fwd  <= r1_fwd;
            r2_eye  <= r1_eye;
            r2_ds   <= DTW'(r1_es[0]) + DTW'(r1_es[1]) + DTW'(r1_es[2]);
            r2_df   <= DTW'(r1_ef[0]) + DTW'(r1_ef[1]) + DTW'(r1_ef[2]);
            for (int j = 0; j < 3; j++) begin
                r2_upn[j] <= round_axis(ud[j]);
            end
        end
    end

    // Eye times up axis; side and forward translation finished.
    logic                           r3_valid;
    logic                           r3_ok;
    logic signed [EPW-1:0]          r3_eu [3];
    logic signed [COORD_W-1:0]      r3_ts;
    logic signed [COORD_W-1:0]      r3_tf;
    logic signed [AXIS_W-1:0]       r3_side [3];
    logic signed [AXIS_W-1:0]       r3_upn [3];
    logic signed [AXIS_W-1:0]       r3_fwd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ok   <= r2_ok;
            r3_side <= r2_side;
            r3_upn  <= r2_upn;
            r3_fwd  <= r2_fwd;
            r3_ts   <= trans_sat(r2_ds);
            r3_tf   <= trans_sat(r2_df);
            for (int j = 0; j < 3; j++) begin
                r3_eu[j] <= r2_eye[j] * r2_upn[j];
            end
        end
    end

    // Up axis dot product.
    logic                           r4_valid;
    logic                           r4_ok;
    logic signed [DTW-1:0]          r4_du;
    logic signed [COORD_W-1:0]      r4_ts;
    logic signed [COORD_W-1:0]      r4_tf;
    logic signed [AXIS_W-1:0]       r4_side [3];
    logic signed [AXIS_W-1:0]       r4_upn [3];
    logic signed [AXIS_W-1:0]       r4_fwd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ok   <= r3_ok;
            r4_side <= r3_side;
            r4_upn  <= r3_upn;
            r4_fwd  <= r3_fwd;
            r4_ts   <= r3_ts;
            r4_tf   <= r3_tf;
            r4_du   <= DTW'(r3_eu[0]) + DTW'(r3_eu[1]) + DTW'(r3_eu[2]);
        end
    end

    // Output register. Degenerate transactions give an all-zero result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                o_side[j] <= r4_ok ? r4_side[j] : '0;
                o_upn[j]  <= r4_ok ? r4_upn[j] : '0;
                o_fwd[j]  <= r4_ok ? r4_fwd[j] : '0;
            end
            o_trans[0] <= r4_ok ? r4_ts : '0;
            o_trans[1] <= r4_ok ? trans_sat(r4_du) : '0;
            o_trans[2] <= r4_ok ? r4_tf : '0;
        end
    end

endmodule

// ===== rtl/look_at_view_matrix_core.sv =====
// ============================================================================
// Look-at view matrix core
// Right-handed view matrix axes and translation from eye, target and up.
// ============================================================================
// The core accepts one transaction per clock while the output is not
// stalled and returns one result per transaction, in order. Each of the
// two normalization pipelines holds a 31-stage square root and a 17-stage
// divider producing one bit per stage. A stall on the output freezes the
// whole pipeline, so the input stall follows the output stall while a
// result is held. If the eye equals the target, or the up hint is zero or
// parallel to the viewing direction, all twelve result fields are zero.
module look_at_view_matrix_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_eye_x,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_eye_y,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_eye_z,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_center_y,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_center_z,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_up_x,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_up_y,
    input  logic signed [lav_pkg::COORD_W-1:0]  i_up_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_side_x,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_side_y,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_side_z,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_upn_x,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_upn_y,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_upn_z,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_fwd_x,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_fwd_y,
    output logic signed [lav_pkg::AXIS_W-1:0]   o_fwd_z,
    output logic signed [lav_pkg::COORD_W-1:0]  o_trans_side,
    output logic signed [lav_pkg::COORD_W-1:0]  o_trans_up,
    output logic signed [lav_pkg::COORD_W-1:0]  o_trans_fwd
);
    import lav_pkg::*;

    localparam int PXW  = COORD_W + DIFF_W;
    localparam int PUW  = COORD_W + AXIS_W;
    localparam int SB1W = 6 * COORD_W;
    localparam int SB2W = 3 * COORD_W + 3 * AXIS_W;

    logic en;

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // Input register with the eye minus target difference.
    logic                           r1_valid;
    logic signed [DIFF_W-1:0]       r1_d [3];
    logic signed [COORD_W-1:0]      r1_eye [3];
    logic signed [COORD_W-1:0]      r1_up [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d[0]   <= DIFF_W'(i_eye_x) - DIFF_W'(i_center_x);
            r1_d[1]   <= DIFF_W'(i_eye_y) - DIFF_W'(i_center_y);
            r1_d[2]   <= DIFF_W'(i_eye_z) - DIFF_W'(i_center_z);
            r1_eye[0] <= i_eye_x;
            r1_eye[1] <= i_eye_y;
            r1_eye[2] <= i_eye_z;
            r1_up[0]  <= i_up_x;
            r1_up[1]  <= i_up_y;
            r1_up[2]  <= i_up_z;
        end
    end

    // Exact cross product terms of up and the difference.
    logic                           r2_valid;
    logic signed [PXW-1:0]          r2_pl [3];
    logic signed [PXW-1:0]          r2_pr [3];
    logic signed [DIFF_W-1:0]       r2_d [3];
    logic signed [COORD_W-1:0]      r2_eye [3];
    logic signed [COORD_W-1:0]      r2_up [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_d     <= r1_d;
            r2_eye   <= r1_eye;
            r2_up    <= r1_up;
            r2_pl[0] <= r1_up[1] * r1_d[2];
            r2_pr[0] <= r1_up[2] * r1_d[1];
            r2_pl[1] <= r1_up[2] * r1_d[0];
            r2_pr[1] <= r1_up[0] * r1_d[2];
            r2_pl[2] <= r1_up[0] * r1_d[1];
            r2_pr[2] <= r1_up[1] * r1_d[0];
        end
    end

    // Parallel test.
    logic                           r3_valid;
    logic                           r3_ok;
    logic signed [DIFF_W-1:0]       r3_d [3];
    logic signed [COORD_W-1:0]      r3_eye [3];
    logic signed [COORD_W-1:0]      r3_up [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_d   <= r2_d;
            r3_eye <= r2_eye;
            r3_up  <= r2_up;
            r3_ok  <= !((r2_pl[0] == r2_pr[0]) && (r2_pl[1] == r2_pr[1])
                        && (r2_pl[2] == r2_pr[2]));
        end
    end

    // Forward axis.
    logic                           n1_valid;
    logic                           n1_ok;
    logic signed [AXIS_W-1:0]       n1_fwd [3];
    logic [SB1W-1:0]                n1_sb;
    logic signed [COORD_W-1:0]      n1_eye [3];
    logic signed [COORD_W-1:0]      n1_up [3];

    lav_norm #(
        .VW  (DIFF_W),
        .SBW (SB1W)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_ok    (r3_ok),
        .i_v     (r3_d),
        .i_sb    ({r3_eye[0], r3_eye[1], r3_eye[2], r3_up[0], r3_up[1], r3_up[2]}),
        .o_valid (n1_valid),
        .o_ok    (n1_ok),
        .o_q     (n1_fwd),
        .o_sb    (n1_sb)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n1_eye[j] = $signed(n1_sb[SB1W-1-COORD_W*j -: COORD_W]);
            n1_up[j]  = $signed(n1_sb[3*COORD_W-1-COORD_W*j -: COORD_W]);
        end
    end

    // Up hint cross forward, products then differences.
    logic                           r4_valid;
    logic                           r4_ok;
    logic signed [PUW-1:0]          r4_pl [3];
    logic signed [PUW-1:0]          r4_pr [3];
    logic signed [AXIS_W-1:0]       r4_fwd [3];
    logic signed [COORD_W-1:0]      r4_eye [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en) begin
            r4_valid <= n1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_ok    <= n1_ok;
            r4_fwd   <= n1_fwd;
            r4_eye   <= n1_eye;
            r4_pl[0] <= n1_up[1] * n1_fwd[2];
            r4_pr[0] <= n1_up[2] * n1_fwd[1];
            r4_pl[1] <= n1_up[2] * n1_fwd[0];
            r4_pr[1] <= n1_up[0] * n1_fwd[2];
            r4_pl[2] <= n1_up[0] * n1_fwd[1];
            r4_pr[2] <= n1_up[1] * n1_fwd[0];
        end
    end

    logic                           r5_valid;
    logic                           r5_ok;
    logic signed [CROSS_W-1:0]      r5_sc [3];
    logic signed [AXIS_W-1:0]       r5_fwd [3];
    logic signed [COORD_W-1:0]      r5_eye [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ok  <= r4_ok;
            r5_fwd <= r4_fwd;
            r5_eye <= r4_eye;
            for (int j = 0; j < 3; j++) begin
                r5_sc[j] <= CROSS_W'(r4_pl[j]) - CROSS_W'(r4_pr[j]);
            end
        end
    end

    // Side axis.
    logic                           n2_valid;
    logic                           n2_ok;
    logic signed [AXIS_W-1:0]       n2_side [3];
    logic [SB2W-1:0]                n2_sb;
    logic signed [COORD_W-1:0]      n2_eye [3];
    logic signed [AXIS_W-1:0]       n2_fwd [3];

    lav_norm #(
        .VW  (CROSS_W),
        .SBW (SB2W)
    ) u_norm_side (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_valid),
        .i_ok    (r5_ok),
        .i_v     (r5_sc),
        .i_sb    ({r5_eye[0], r5_eye[1], r5_eye[2], r5_fwd[0], r5_fwd[1], r5_fwd[2]}),
        .o_valid (n2_valid),
        .o_ok    (n2_ok),
        .o_q     (n2_side),
        .o_sb    (n2_sb)
    );

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n2_eye[j] = $signed(n2_sb[SB2W-1-COORD_W*j -: COORD_W]);
            n2_fwd[j] = $signed(n2_sb[3*AXIS_W-1-AXIS_W*j -: AXIS_W]);
        end
    end

    // Up axis, translation and output register.
    logic signed [AXIS_W-1:0]       b_side [3];
    logic signed [AXIS_W-1:0]       b_upn [3];
    logic signed [AXIS_W-1:0]       b_fwd [3];
    logic signed [COORD_W-1:0]      b_trans [3];

    lav_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (n2_valid),
        .i_ok    (n2_ok),
        .i_fwd   (n2_fwd),
        .i_side  (n2_side),
        .i_eye   (n2_eye),
        .o_valid (o_valid),
        .o_side  (b_side),
        .o_upn   (b_upn),
        .o_fwd   (b_fwd),
        .o_trans (b_trans)
    );

    assign o_side_x     = b_side[0];
    assign o_side_y     = b_side[1];
    assign o_side_z     = b_side[2];
    assign o_upn_x      = b_upn[0];
    assign o_upn_y      = b_upn[1];
    assign o_upn_z      = b_upn[2];
    assign o_fwd_x      = b_fwd[0];
    assign o_fwd_y      = b_fwd[1];
    assign o_fwd_z      = b_fwd[2];
    assign o_trans_side = b_trans[0];
    assign o_trans_up   = b_trans[1];
    assign o_trans_fwd  = b_trans[2];

endmodule

// ===== bench/look_at_view_matrix_core_test.sv =====
// ============================================================================
// Look-at view matrix core testbench
// Drives eye, target and up transactions with random gaps and output stalls,
// predicts the view axes and translation in fixed point, and compares each
// result in order against the expected queue.
// ============================================================================
module look_at_view_matrix_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lav_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] ex, ey, ez, cx, cy, cz, ux, uy, uz;
    } t_view_in;

    typedef struct packed {
        logic signed [AXIS_W-1:0]  sx, sy, sz, ux, uy, uz, fx, fy, fz;
        logic signed [COORD_W-1:0] ts, tu, tf;
    } t_view_out;

    localparam int WATCHDOG = 5000;
    localparam int RANDOM_ITEMS = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [COORD_W-1:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic signed [COORD_W-1:0] i_center_x = '0, i_center_y = '0, i_center_z = '0;
    logic signed [COORD_W-1:0] i_up_x = '0, i_up_y = '0, i_up_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [AXIS_W-1:0] o_side_x, o_side_y, o_side_z;
    logic signed [AXIS_W-1:0] o_upn_x, o_upn_y, o_upn_z;
    logic signed [AXIS_W-1:0] o_fwd_x, o_fwd_y, o_fwd_z;
    logic signed [COORD_W-1:0] o_trans_side, o_trans_up, o_trans_fwd;

    t_view_in  pending_views[$];
    t_view_out expected_views[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  stimulus_done = 1'b0;

    look_at_view_matrix_core i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] round_q16(input logic signed [63:0] x);
        logic [63:0] m;
        m = (magnitude(x) + 64'd32768) >> 16;
        return x < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic bit unit_vector(input logic signed [63:0] v[3],
                                       output logic signed [63:0] u[3]);
        logic [63:0] m[3];
        logic [63:0] top, s, len, q;
        int p;
        top = 0;
        s = 0;
        p = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(v[i]);
            if (m[i] > top) top = m[i];
        end
        if (top == 0) return 1'b0;
        while (p < 63 && (top >> (p + 1)) != 0) p++;
        for (int i = 0; i < 3; i++) begin
            if (p > NORM_TOP) m[i] = m[i] >> (p - NORM_TOP);
            else m[i] = m[i] << (NORM_TOP - p);
            s = s + m[i] * m[i];
        end
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 64'd65536 + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1'b1;
    endfunction

    function automatic logic signed [63:0] clamp_unit(input logic signed [63:0] x);
        if (x > 65536) return 65536;
        if (x < -65536) return -65536;
        return x;
    endfunction

    function automatic logic signed [31:0] translation(input logic signed [63:0] e[3],
                                                       input logic signed [63:0] a[3]);
        logic signed [63:0] t;
        t = -round_q16(e[0] * a[0] + e[1] * a[1] + e[2] * a[2]);
        if (t > 64'sd2147483647) return 32'sh7fffffff;
        if (t < -64'sd2147483648) return 32'sh80000000;
        return t[31:0];
    endfunction

    function automatic t_view_out predict_view(input t_view_in v);
        logic signed [63:0] eye[3], up[3], d[3], fwd[3], cr[3], side[3], upn[3];
        t_view_out r;
        bit ok;
        r = '0;
        eye = '{v.ex, v.ey, v.ez};
        up = '{v.ux, v.uy, v.uz};
        d = '{eye[0] - v.cx, eye[1] - v.cy, eye[2] - v.cz};
        ok = unit_vector(d, fwd);
        if (ok && up[1] * d[2] == up[2] * d[1] && up[2] * d[0] == up[0] * d[2]
            && up[0] * d[1] == up[1] * d[0]) ok = 1'b0;
        if (ok) begin
            cr[0] = up[1] * fwd[2] - up[2] * fwd[1];
            cr[1] = up[2] * fwd[0] - up[0] * fwd[2];
            cr[2] = up[0] * fwd[1] - up[1] * fwd[0];
            ok = unit_vector(cr, side);
        end
        if (ok) begin
            upn[0] = clamp_unit(round_q16(fwd[1] * side[2] - fwd[2] * side[1]));
            upn[1] = clamp_unit(round_q16(fwd[2] * side[0] - fwd[0] * side[2]));
            upn[2] = clamp_unit(round_q16(fwd[0] * side[1] - fwd[1] * side[0]));
            r.sx = AXIS_W'(side[0]); r.sy = AXIS_W'(side[1]); r.sz = AXIS_W'(side[2]);
            r.ux = AXIS_W'(upn[0]);  r.uy = AXIS_W'(upn[1]);  r.uz = AXIS_W'(upn[2]);
            r.fx = AXIS_W'(fwd[0]);  r.fy = AXIS_W'(fwd[1]);  r.fz = AXIS_W'(fwd[2]);
            r.ts = translation(eye, side);
            r.tu = translation(eye, upn);
            r.tf = translation(eye, fwd);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 20)) - 10;
            2: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            3: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                           : 32'sh80000000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
        endcase
    endfunction

    function automatic t_view_in random_view();
        t_view_in v;
        int k;
        v = {random_coord(), random_coord(), random_coord(), random_coord(),
             random_coord(), random_coord(), random_coord(), random_coord(),
             random_coord()};
        case ($urandom_range(0, 19))
            0: begin
                v.cx = v.ex; v.cy = v.ey; v.cz = v.ez;
            end
            1: begin
                k = $signed($urandom_range(0, 6)) - 3;
                v.ux = k * (v.ex - v.cx);
                v.uy = k * (v.ey - v.cy);
                v.uz = k * (v.ez - v.cz);
            end
            2: begin
                v.ux = 0; v.uy = 0; v.uz = 0;
            end
            3: begin
                v.cx = v.ex + $signed($urandom_range(0, 4)) - 2;
                v.cy = v.ey; v.cz = v.ez;
                v.ux = 0; v.uy = $urandom_range(0, 1) ? 1 : -1; v.uz = 1;
            end
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        pending_views.push_back('{0, 0, 65536, 0, 0, 0, 0, 65536, 0});
        pending_views.push_back('{mx, mx, mx, mn, mn, mn, mn, mx, 0});
        pending_views.push_back('{mn, mn, mn, mx, mx, mx, mx, mn, 5});
        pending_views.push_back('{mx, 0, 0, mn, 0, 0, 0, 0, mx});
        pending_views.push_back('{mn, mx, mn, mx, mn, mx, 1, 0, 0});
        pending_views.push_back('{5, 6, 7, 5, 6, 7, 0, 65536, 0});
        pending_views.push_back('{1, 2, 3, 0, 0, 0, 0, 0, 0});
        pending_views.push_back('{2, 4, 6, 1, 2, 3, 3, 6, 9});
        pending_views.push_back('{0, 0, 1, 0, 0, 0, 0, 0, mn});
        pending_views.push_back('{1, 0, 1, 0, 0, 0, 0, 1, 1});
        pending_views.push_back('{-1, -1, -1, 0, 0, 0, -1, 1, 0});
        pending_views.push_back('{mx, mx, mx, 0, 0, 0, mx, mn, mx});
        pending_views.push_back('{mn, mn, mn, -1, -1, -1, 1, 2, 3});
        pending_views.push_back('{32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f,
                                  0, 0, 0, 32'shf0f0f0f0, 32'sh33333333, mn});
        for (int i = 0; i < RANDOM_ITEMS; i++) pending_views.push_back(random_view());
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_views.push_back(predict_view({i_eye_x, i_eye_y, i_eye_z,
                    i_center_x, i_center_y, i_center_z, i_up_x, i_up_y, i_up_z}));
            end
            if (!i_valid || !o_stall) begin
                if (send_wait > 0 || pending_views.size() == 0) begin
                    i_valid <= 1'b0;
                    if (send_wait > 0) send_wait <= send_wait - 1;
                    if (pending_views.size() == 0) stimulus_done <= 1'b1;
                end else begin
                    t_view_in v;
                    v = pending_views.pop_front();
                    i_valid <= 1'b1;
                    {i_eye_x, i_eye_y, i_eye_z, i_center_x, i_center_y, i_center_z,
                     i_up_x, i_up_y, i_up_z} <= v;
                    send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                t_view_out got, want;
                int w;
                got = {o_side_x, o_side_y, o_side_z, o_upn_x, o_upn_y, o_upn_z,
                       o_fwd_x, o_fwd_y, o_fwd_z, o_trans_side, o_trans_up, o_trans_fwd};
                if (expected_views.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected transaction: %p", got);
                end else begin
                    want = expected_views.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %p, actual %p", want, got);
                    end
                end
                w = $urandom_range(0, 9);
                recv_wait <= (w > 0) ? w - 1 : 0;
                i_stall <= (w > 0);
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (stimulus_done && expected_views.size() == 0) begin
                repeat (150) @(posedge i_clk);
                if (mismatches == 0 && !o_valid) begin
                    $display("[ OK ] regression clean");
                end else begin
                    $display("[FAIL] regression broken");
                end
                $finish;
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/lav_pkg.sv
rtl/lav_norm.sv
rtl/lav_back.sv
rtl/look_at_view_matrix_core.sv
bench/look_at_view_matrix_core_test.sv
